>>> rtl/jlrf_pkg.sv
// Shared types, constants and helper functions of the jerk-limited reference filter.
package jlrf_pkg;

    // Fixed-point format and tick rate
    localparam int FRAC_BITS        = 16;
    localparam int TICKS_PER_SECOND = 100;

    // Field widths
    localparam int POS_W   = 32;
    localparam int YAW_W   = 19;
    localparam int GAIN_W  = 23;
    localparam int LIMIT_W = 20;
    localparam int ERR_W   = 34;
    localparam int MUL_AW  = 24;
    localparam int MUL_BW  = ERR_W;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int WIDE_W  = 60;
    // acceleration and velocity stay within +/- a limit
    localparam int DER_W   = LIMIT_W + 1;

    // Division by the tick rate: multiply by a rounded-up reciprocal.
    // Exact for every dividend below 2^LIMIT_W.
    localparam int DIV_L  = $clog2(TICKS_PER_SECOND);
    localparam int DIV_SH = LIMIT_W + DIV_L;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SH) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
    localparam logic signed [MUL_AW-1:0] RECIP = MUL_AW'(RECIP_L);

    // pi and two pi in the working format
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint PI_FX_L   = PI_Q30 >>> (30 - FRAC_BITS);
    localparam longint TWOPI_FX_L = (PI_Q30 * 2) >>> (30 - FRAC_BITS);
    localparam logic signed [ERR_W-1:0] PI_FX    = ERR_W'(PI_FX_L);
    localparam logic signed [ERR_W-1:0] TWOPI_FX = ERR_W'(TWOPI_FX_L);

    // Register indices
    localparam logic [2:0] REG_POS_GAIN     = 3'd0;
    localparam logic [2:0] REG_DAMP_GAIN    = 3'd1;
    localparam logic [2:0] REG_LIN_JERK_MAX = 3'd2;
    localparam logic [2:0] REG_LIN_ACC_MAX  = 3'd3;
    localparam logic [2:0] REG_LIN_VEL_MAX  = 3'd4;
    localparam logic [2:0] REG_YAW_JERK_MAX = 3'd5;
    localparam logic [2:0] REG_YAW_ACC_MAX  = 3'd6;
    localparam logic [2:0] REG_YAW_VEL_MAX  = 3'd7;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]  pos_gain;
        logic [GAIN_W-1:0]  damp_gain;
        logic [LIMIT_W-1:0] lin_jerk_max;
        logic [LIMIT_W-1:0] lin_acc_max;
        logic [LIMIT_W-1:0] lin_vel_max;
        logic [LIMIT_W-1:0] yaw_jerk_max;
        logic [LIMIT_W-1:0] yaw_acc_max;
        logic [LIMIT_W-1:0] yaw_vel_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pos_gain:     23'd65536,
        damp_gain:    23'd65536,
        lin_jerk_max: 20'd22938,
        lin_acc_max:  20'd49152,
        lin_vel_max:  20'd98304,
        yaw_jerk_max: 20'd22938,
        yaw_acc_max:  20'd49152,
        yaw_vel_max:  20'd98304
    };

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] target_x;
        logic [POS_W-1:0] target_y;
        logic [POS_W-1:0] target_z;
        logic [YAW_W-1:0] target_yaw;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] desired_x;
        logic [POS_W-1:0] desired_y;
        logic [POS_W-1:0] desired_z;
        logic [POS_W-1:0] desired_yaw;
    } pose_t;

    // Symmetric clamp to +/- lim; result always fits DER_W bits
    function automatic logic signed [DER_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] x,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [DER_W-1:0]  res;
        hi = $signed({{(WIDE_W-LIMIT_W){1'b0}}, lim});
        lo = -hi;
        if (x > hi)
        begin
            res = $signed({1'b0, lim});
        end
        else if (x < lo)
        begin
            res = -$signed({1'b0, lim});
        end
        else
        begin
            res = x[DER_W-1:0];
        end
        return res;
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W+1:0] x);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        logic signed [POS_W-1:0] res;
        hi = $signed({3'b000, {(POS_W-1){1'b1}}});
        lo = -hi - 1;
        if (x > hi)
        begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (x < lo)
        begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            res = x[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/jlrf_if.sv
// Valid/ready channel interfaces for commanded poses and desired poses.
interface jlrf_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [jlrf_pkg::POS_W-1:0] target_x;
    logic signed [jlrf_pkg::POS_W-1:0] target_y;
    logic signed [jlrf_pkg::POS_W-1:0] target_z;
    logic signed [jlrf_pkg::YAW_W-1:0] target_yaw;

    modport source (output valid, cmd, target_x, target_y, target_z, target_yaw,
                    input ready);
    modport sink   (input valid, cmd, target_x, target_y, target_z, target_yaw,
                    output ready);
endinterface

interface jlrf_pose_if;
    logic                          valid;
    logic                          ready;
    logic signed [jlrf_pkg::POS_W-1:0] desired_x;
    logic signed [jlrf_pkg::POS_W-1:0] desired_y;
    logic signed [jlrf_pkg::POS_W-1:0] desired_z;
    logic signed [jlrf_pkg::POS_W-1:0] desired_yaw;

    modport source (output valid, desired_x, desired_y, desired_z, desired_yaw,
                    input ready);
    modport sink   (input valid, desired_x, desired_y, desired_z, desired_yaw,
                    output ready);
endinterface

>>> rtl/jlrf_mul.sv
// Shared signed multiplier with registered product.
module jlrf_mul (
    input  logic                                  clk,
    input  logic signed [jlrf_pkg::MUL_AW-1:0]    a,
    input  logic signed [jlrf_pkg::MUL_BW-1:0]    b,
    output logic signed [jlrf_pkg::PROD_W-1:0]    p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

>>> rtl/jlrf_core.sv
// Sequencer and state of the four reference-model channels around one multiplier.
module jlrf_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  jlrf_pkg::item_t     item,
    input  jlrf_pkg::cfg_t      cfg,
    output logic                idle,
    output logic                done,
    input  logic                done_ready,
    output jlrf_pkg::pose_t     pose
);

    localparam int POS_W  = jlrf_pkg::POS_W;
    localparam int DER_W  = jlrf_pkg::DER_W;
    localparam int ERR_W  = jlrf_pkg::ERR_W;
    localparam int WIDE_W = jlrf_pkg::WIDE_W;
    localparam int PROD_W = jlrf_pkg::PROD_W;
    localparam int LIM_W  = jlrf_pkg::LIMIT_W;
    localparam int SH     = jlrf_pkg::DIV_SH;
    localparam int DIFF_W = PROD_W + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ERR    = 4'd1;
    localparam logic [3:0] ST_M_DMAX = 4'd2;
    localparam logic [3:0] ST_M_KP   = 4'd3;
    localparam logic [3:0] ST_M_KD   = 4'd4;
    localparam logic [3:0] ST_RAW    = 4'd5;
    localparam logic [3:0] ST_JERK   = 4'd6;
    localparam logic [3:0] ST_ACC    = 4'd7;
    localparam logic [3:0] ST_M_ADIV = 4'd8;
    localparam logic [3:0] ST_VEL    = 4'd9;
    localparam logic [3:0] ST_M_VDIV = 4'd10;
    localparam logic [3:0] ST_POS    = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    localparam logic [1:0] CH_YAW = 2'd3;

    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic [1:0] ch_reg;
    logic [1:0] ch_next;

    logic signed [POS_W-1:0]  tgt_reg [4];
    logic signed [POS_W-1:0]  pos_reg [4];
    logic signed [DER_W-1:0]  vel_reg [4];
    logic signed [DER_W-1:0]  acc_reg [4];

    logic signed [ERR_W-1:0]  err_reg;
    logic [LIM_W-1:0]         dmax_reg;
    logic signed [PROD_W-1:0] sum_reg;
    logic signed [WIDE_W-1:0] raw_reg;
    logic signed [DER_W-1:0]  dcl_reg;
    logic                     neg_reg;

    logic signed [jlrf_pkg::MUL_AW-1:0] mul_a;
    logic signed [jlrf_pkg::MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0]           p_reg;

    logic signed [POS_W-1:0]  cur_tgt;
    logic signed [POS_W-1:0]  cur_pos;
    logic signed [DER_W-1:0]  cur_vel;
    logic signed [DER_W-1:0]  cur_acc;
    logic                     is_yaw;
    logic [LIM_W-1:0]         jerk_lim;
    logic [LIM_W-1:0]         acc_lim;
    logic [LIM_W-1:0]         vel_lim;
    logic signed [ERR_W-1:0]  err_raw;
    logic signed [ERR_W-1:0]  err_val;
    logic [LIM_W-1:0]         quot;
    logic signed [DER_W:0]    q_signed;
    logic signed [DIFF_W-1:0] pd_diff;
    logic signed [DIFF_W-1:0] raw_val;
    logic signed [DER_W-1:0]  dcl_val;
    logic signed [DER_W-1:0]  acc_val;
    logic signed [DER_W-1:0]  vel_val;
    logic signed [POS_W-1:0]  pos_val;
    logic signed [ERR_W-1:0]  acc_mag;
    logic signed [ERR_W-1:0]  vel_mag;

    jlrf_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (p_reg)
    );

    assign cur_tgt = tgt_reg[ch_reg];
    assign cur_pos = pos_reg[ch_reg];
    assign cur_vel = vel_reg[ch_reg];
    assign cur_acc = acc_reg[ch_reg];
    assign is_yaw  = (ch_reg == CH_YAW);

    assign jerk_lim = is_yaw ? cfg.yaw_jerk_max : cfg.lin_jerk_max;
    assign acc_lim  = is_yaw ? cfg.yaw_acc_max  : cfg.lin_acc_max;
    assign vel_lim  = is_yaw ? cfg.yaw_vel_max  : cfg.lin_vel_max;

    // error, with a single wrap into +/- pi on the yaw channel
    always_comb
    begin
        err_raw = ERR_W'(cur_tgt) - ERR_W'(cur_pos);
        err_val = err_raw;
        if (is_yaw)
        begin
            if (err_raw > jlrf_pkg::PI_FX)
            begin
                err_val = err_raw - jlrf_pkg::TWOPI_FX;
            end
            else if (err_raw < -jlrf_pkg::PI_FX)
            begin
                err_val = err_raw + jlrf_pkg::TWOPI_FX;
            end
        end
    end

    // quotient by the tick rate, truncated toward zero
    assign quot     = p_reg[SH+LIM_W-1:SH];
    assign q_signed = neg_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

    assign pd_diff = DIFF_W'(sum_reg) - DIFF_W'(p_reg);
    assign raw_val = pd_diff >>> jlrf_pkg::FRAC_BITS;

    assign dcl_val = jlrf_pkg::clamp_sym(raw_reg - WIDE_W'(cur_acc), dmax_reg);
    assign acc_val = jlrf_pkg::clamp_sym(WIDE_W'(cur_acc) + WIDE_W'(dcl_reg), acc_lim);
    assign vel_val = jlrf_pkg::clamp_sym(WIDE_W'(cur_vel) + WIDE_W'(q_signed), vel_lim);
    assign pos_val = jlrf_pkg::sat32((POS_W+2)'(cur_pos) + (POS_W+2)'(q_signed));

    assign acc_mag = cur_acc[DER_W-1] ? -ERR_W'(cur_acc) : ERR_W'(cur_acc);
    assign vel_mag = cur_vel[DER_W-1] ? -ERR_W'(cur_vel) : ERR_W'(cur_vel);

    always_comb
    begin
        case (step_reg)
            ST_M_DMAX:
            begin
                mul_a = jlrf_pkg::RECIP;
                mul_b = $signed({{(ERR_W-LIM_W){1'b0}}, jerk_lim});
            end
            ST_M_KP:
            begin
                mul_a = $signed({1'b0, cfg.pos_gain});
                mul_b = err_reg;
            end
            ST_M_KD:
            begin
                mul_a = $signed({1'b0, cfg.damp_gain});
                mul_b = ERR_W'(cur_vel);
            end
            ST_M_ADIV:
            begin
                mul_a = jlrf_pkg::RECIP;
                mul_b = acc_mag;
            end
            ST_M_VDIV:
            begin
                mul_a = jlrf_pkg::RECIP;
                mul_b = vel_mag;
            end
            default:
            begin
                mul_a = $signed({1'b0, cfg.pos_gain});
                mul_b = err_reg;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        ch_next   = ch_reg;
        case (step_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ch_next   = 2'd0;
                    step_next = (item.cmd == jlrf_pkg::CMD_INIT) ? ST_DONE : ST_ERR;
                end
            end
            ST_ERR:    step_next = ST_M_DMAX;
            ST_M_DMAX: step_next = ST_M_KP;
            ST_M_KP:   step_next = ST_M_KD;
            ST_M_KD:   step_next = ST_RAW;
            ST_RAW:    step_next = ST_JERK;
            ST_JERK:   step_next = ST_ACC;
            ST_ACC:    step_next = ST_M_ADIV;
            ST_M_ADIV: step_next = ST_VEL;
            ST_VEL:    step_next = ST_M_VDIV;
            ST_M_VDIV: step_next = ST_POS;
            ST_POS:
            begin
                if (ch_reg == CH_YAW)
                begin
                    step_next = ST_DONE;
                end
                else
                begin
                    ch_next   = ch_reg + 2'd1;
                    step_next = ST_ERR;
                end
            end
            ST_DONE:
            begin
                if (done_ready)
                begin
                    step_next = ST_IDLE;
                end
            end
            default:   step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            ch_reg   <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
            ch_reg   <= ch_next;
        end
    end

    // model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            case (step_reg)
                ST_IDLE:
                begin
                    if (start && item.cmd == jlrf_pkg::CMD_INIT)
                    begin
                        pos_reg[0] <= $signed(item.target_x);
                        pos_reg[1] <= $signed(item.target_y);
                        pos_reg[2] <= $signed(item.target_z);
                        pos_reg[3] <= POS_W'($signed(item.target_yaw));
                        for (int i = 0; i < 4; i++)
                        begin
                            vel_reg[i] <= '0;
                            acc_reg[i] <= '0;
                        end
                    end
                end
                ST_ACC: acc_reg[ch_reg] <= acc_val;
                ST_VEL: vel_reg[ch_reg] <= vel_val;
                ST_POS: pos_reg[ch_reg] <= pos_val;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (step_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    tgt_reg[0] <= $signed(item.target_x);
                    tgt_reg[1] <= $signed(item.target_y);
                    tgt_reg[2] <= $signed(item.target_z);
                    tgt_reg[3] <= POS_W'($signed(item.target_yaw));
                end
            end
            ST_ERR:    err_reg  <= err_val;
            ST_M_KP:   dmax_reg <= quot;
            ST_M_KD:   sum_reg  <= p_reg;
            ST_RAW:    raw_reg  <= WIDE_W'(raw_val);
            ST_JERK:   dcl_reg  <= dcl_val;
            ST_M_ADIV: neg_reg  <= cur_acc[DER_W-1];
            ST_M_VDIV: neg_reg  <= cur_vel[DER_W-1];
            default: ;
        endcase
    end

    assign idle = (step_reg == ST_IDLE);
    assign done = (step_reg == ST_DONE);

    assign pose.desired_x   = pos_reg[0];
    assign pose.desired_y   = pos_reg[1];
    assign pose.desired_z   = pos_reg[2];
    assign pose.desired_yaw = pos_reg[3];

endmodule

>>> rtl/jerk_limited_reference_filter.sv
// Top level: configuration registers, command intake and desired-pose output register.
// Filter step: the sequencer runs 11 steps per channel on one shared 24x34 multiplier,
// then hands the result to the output register; a new command is taken only after the
// hand-off, once the sequencer is idle again. Init loads the pose, zeroes derivatives
// and goes straight to hand-off. A full output register that is not drained holds the sequencer in its hand-off step.
// Reset (asynchronous, active low) loads default gains and limits, zeroes pose and
// derivatives and empties the output register.
module jerk_limited_reference_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    jlrf_cmd_if.sink                          command,
    jlrf_pose_if.source                       pose,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [jlrf_pkg::GAIN_W-1:0]       cfg_data
);

    localparam int LIM_W = jlrf_pkg::LIMIT_W;

    jlrf_pkg::cfg_t  cfg_reg;
    jlrf_pkg::item_t item;
    jlrf_pkg::pose_t core_pose;
    jlrf_pkg::pose_t pose_reg;
    logic            out_valid_reg;
    logic            core_idle;
    logic            core_done;
    logic            done_ready;
    logic            start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= jlrf_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jlrf_pkg::REG_POS_GAIN:     cfg_reg.pos_gain     <= cfg_data;
                jlrf_pkg::REG_DAMP_GAIN:    cfg_reg.damp_gain    <= cfg_data;
                jlrf_pkg::REG_LIN_JERK_MAX: cfg_reg.lin_jerk_max <= cfg_data[LIM_W-1:0];
                jlrf_pkg::REG_LIN_ACC_MAX:  cfg_reg.lin_acc_max  <= cfg_data[LIM_W-1:0];
                jlrf_pkg::REG_LIN_VEL_MAX:  cfg_reg.lin_vel_max  <= cfg_data[LIM_W-1:0];
                jlrf_pkg::REG_YAW_JERK_MAX: cfg_reg.yaw_jerk_max <= cfg_data[LIM_W-1:0];
                jlrf_pkg::REG_YAW_ACC_MAX:  cfg_reg.yaw_acc_max  <= cfg_data[LIM_W-1:0];
                jlrf_pkg::REG_YAW_VEL_MAX:  cfg_reg.yaw_vel_max  <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign command.ready = core_idle;
    assign start         = command.valid && core_idle;

    assign item.cmd        = command.cmd;
    assign item.target_x   = command.target_x;
    assign item.target_y   = command.target_y;
    assign item.target_z   = command.target_z;
    assign item.target_yaw = command.target_yaw;

    jlrf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .cfg        (cfg_reg),
        .idle       (core_idle),
        .done       (core_done),
        .done_ready (done_ready),
        .pose       (core_pose)
    );

    // result is handed over only when the output register is free or being drained
    assign done_ready = !out_valid_reg || pose.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_done && done_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pose.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done && done_ready)
        begin
            pose_reg <= core_pose;
        end
    end

    assign pose.valid       = out_valid_reg;
    assign pose.desired_x   = pose_reg.desired_x;
    assign pose.desired_y   = pose_reg.desired_y;
    assign pose.desired_z   = pose_reg.desired_z;
    assign pose.desired_yaw = pose_reg.desired_yaw;

endmodule
